>>> rtl/top_k_score_list_top_defines.svh
// Assertion macros for the top-k score list.
`ifndef TOP_K_SCORE_LIST_TOP_DEFINES_SVH
`define TOP_K_SCORE_LIST_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TKL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TKL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TKL_ASSERT(label, prop, msg)
`define TKL_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/tkl_pkg.sv
// Shared types and constants for the top-k score list.
package tkl_pkg;

    localparam int SCORE_W  = 16;
    localparam int LINK_W   = 16;
    localparam int RULE_W   = 12;
    localparam int RIDX_W   = 3;
    localparam int SLOT_W   = 3;
    localparam int FILL_W   = 4;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef struct packed {
        logic insert;
        logic clear;
    } t_cell_ctrl;

endpackage

>>> rtl/tkl_cell.sv
// One list cell: holds an entry and takes the new item or its neighbor's entry.
module tkl_cell import tkl_pkg::*; #(
    parameter int ENTRY_W = 60
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic [ENTRY_W-1:0] i_new,
    input  logic [ENTRY_W-1:0] i_prev,
    input  logic               i_prev_valid,
    input  logic               i_prev_take,
    output logic [ENTRY_W-1:0] o_entry,
    output logic               o_valid,
    output logic               o_take
);

    logic [ENTRY_W-1:0] r_entry;
    logic               r_valid;

    // empty cells and cells beaten by the new score give way
    assign o_take  = !r_valid || (r_entry[SCORE_W-1:0] < i_new[SCORE_W-1:0]);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.insert && o_take) begin
            r_valid <= i_prev_take ? i_prev_valid : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert && o_take) begin
            r_entry <= i_prev_take ? i_prev : i_new;
        end
    end

endmodule

>>> rtl/top_k_score_list_top.sv
// Top-k score list: a chain of entry cells kept in descending score order.
//
// Input channel (s_axis): one item is an operation. tuser carries the opcode
// (insert, read, clear); tdata carries score, rule number, two link tags and
// the read index. Output channel (m_axis): one result item per input item,
// with insert status, fill count and the read entry fields.
// Each cell compares its stored score with the new one in parallel; the
// first cell that gives way loads the new entry, later cells load their
// upper neighbor's entry, and the last entry falls off a full list.
// The result is registered and valid in the cycle after input accept. One
// item per cycle is taken unless the output stalls, set by the single
// compare-and-shift step of the cells. The output register frees on the
// cycle its result is taken, so items flow back to back while the receiver
// keeps tready high; while it stalls, the held result blocks s_axis_tready.
// Reset empties the list (all cell valid bits and the fill count cleared)
// and drops any pending result; entry payloads are not cleared.
`include "top_k_score_list_top_defines.svh"
module top_k_score_list_top import tkl_pkg::*; #(
    parameter int LIST_DEPTH = 8,
    parameter int RULE_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] score, [27:16] rule_number, [43:28] link_a, [59:44] link_b,
    // [62:60] read_index, [63] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] accepted, [3:1] slot, [4] evicted, [8:5] fill_count, [9] entry_valid,
    // [25:10] out_score, [37:26] out_rule, [53:38] out_link_a,
    // [69:54] out_link_b, [71:70] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int ENTRY_W = SCORE_W + RULE_BITS + 2 * LINK_W;
    localparam int KEEP_W  = (RULE_BITS < RULE_W) ? RULE_BITS : RULE_W;
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [ENTRY_W-1:0]    w_entry [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_valid;
    logic [LIST_DEPTH-1:0] w_take;
    logic [ENTRY_W-1:0]    w_new;
    logic [RULE_BITS-1:0]  w_rule_in;
    t_cell_ctrl            w_ctrl;
    t_opcode               w_op;
    logic                  w_in_acc;

    logic [SCORE_W-1:0]    in_score;
    logic [RULE_W-1:0]     in_rule;
    logic [LINK_W-1:0]     in_link_a;
    logic [LINK_W-1:0]     in_link_b;
    logic [RIDX_W-1:0]     in_ridx;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic                  res_accepted;
    logic [SLOT_W-1:0]     res_slot;
    logic                  res_evicted;
    logic                  res_entry_valid;
    logic [SCORE_W-1:0]    res_score;
    logic [RULE_W-1:0]     res_rule;
    logic [LINK_W-1:0]     res_link_a;
    logic [LINK_W-1:0]     res_link_b;
    logic [IDX_W-1:0]      w_land_idx;
    logic [ENTRY_W-1:0]    w_sel;
    logic                  w_sel_valid;

    assign in_score  = s_axis_tdata[15:0];
    assign in_rule   = s_axis_tdata[27:16];
    assign in_link_a = s_axis_tdata[43:28];
    assign in_link_b = s_axis_tdata[59:44];
    assign in_ridx   = s_axis_tdata[62:60];
    assign w_op      = t_opcode'(s_axis_tuser);

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        w_rule_in = '0;
        w_rule_in[KEEP_W-1:0] = in_rule[KEEP_W-1:0];
    end

    assign w_new = {in_link_b, in_link_a, w_rule_in, in_score};

    for (genvar gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            tkl_cell #(.ENTRY_W(ENTRY_W)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_prev       (w_new),
                .i_prev_valid (1'b0),
                .i_prev_take  (1'b0),
                .o_entry      (w_entry[gi]),
                .o_valid      (w_valid[gi]),
                .o_take       (w_take[gi])
            );
        end else begin : g_body
            tkl_cell #(.ENTRY_W(ENTRY_W)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_prev       (w_entry[gi-1]),
                .i_prev_valid (w_valid[gi-1]),
                .i_prev_take  (w_take[gi-1]),
                .o_entry      (w_entry[gi]),
                .o_valid      (w_valid[gi]),
                .o_take       (w_take[gi])
            );
        end
    end

    // landing slot: the first cell that gives way; read select by index
    always_comb begin
        w_land_idx  = '0;
        w_sel       = '0;
        w_sel_valid = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (w_take[i] && (i == 0 || !w_take[(i > 0) ? i - 1 : 0])) begin
                w_land_idx = w_land_idx | IDX_W'(i);
            end
            if (int'(in_ridx) == i) begin
                w_sel       = w_sel | w_entry[i];
                w_sel_valid = w_sel_valid | w_valid[i];
            end
        end
    end

    always_comb begin
        n_count         = r_count;
        w_ctrl          = '0;
        res_accepted    = 1'b0;
        res_slot        = '0;
        res_evicted     = 1'b0;
        res_entry_valid = 1'b0;
        res_score       = '0;
        res_rule        = '0;
        res_link_a      = '0;
        res_link_b      = '0;
        case (w_op)
            OP_INSERT: begin
                w_ctrl.insert = w_in_acc;
                res_accepted  = w_take[LIST_DEPTH-1];
                res_evicted   = w_valid[LIST_DEPTH-1] && w_take[LIST_DEPTH-1];
                if (res_accepted) begin
                    res_slot = SLOT_W'(w_land_idx);
                end
                if (res_accepted && !res_evicted) begin
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            OP_READ: begin
                if (w_sel_valid) begin
                    res_entry_valid = 1'b1;
                    res_score       = w_sel[SCORE_W-1:0];
                    res_rule[KEEP_W-1:0] = w_sel[SCORE_W +: KEEP_W];
                    res_link_a      = w_sel[SCORE_W + RULE_BITS +: LINK_W];
                    res_link_b      = w_sel[SCORE_W + RULE_BITS + LINK_W +: LINK_W];
                end
            end
            OP_CLEAR: begin
                w_ctrl.clear = w_in_acc;
                n_count      = '0;
            end
            default: begin
            end
        endcase
        n_out_data = {2'b00, res_link_b, res_link_a, res_rule, res_score,
                      res_entry_valid, FILL_W'(n_count), res_evicted, res_slot,
                      res_accepted};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_data <= n_out_data;
        end
    end

    `TKL_ASSERT(a_count_matches_cells, (32'(r_count) == $countones(w_valid)), "fill count differs from valid cells")
    `TKL_ASSERT(a_clear_empties, (w_in_acc && w_op == OP_CLEAR) |=> (r_count == '0), "clear left entries")
    `TKL_ASSERT(a_drop_keeps_list, (w_in_acc && w_op == OP_INSERT && !w_take[LIST_DEPTH-1]) |=> $stable(w_valid), "dropped insert changed the list")
    `TKL_ASSERT(a_evict_only_full, (w_in_acc && w_op == OP_INSERT && res_evicted) |-> (32'(r_count) == LIST_DEPTH), "eviction from a list that is not full")

endmodule
